FILE: sv/fir_valid_convolution_unit_assert.svh
// -----------------------------------------------------------------------------
// FIR valid-convolution unit: assertion macros
// Shared concurrent checks, clocked on the rising edge, off during reset.
// -----------------------------------------------------------------------------
`ifndef FIR_VALID_CONVOLUTION_UNIT_ASSERT_SVH
`define FIR_VALID_CONVOLUTION_UNIT_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define FVC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Check that a condition implies another in the next cycle
`define FVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

FILE: sv/fvc_pkg.sv
// -----------------------------------------------------------------------------
// FIR valid-convolution package
// Widths, payload types and register codes shared by the filter modules.
// -----------------------------------------------------------------------------
package fvc_pkg;

   localparam int FVC_MAX_TAPS      = 7;
   localparam int FVC_SAMPLE_W      = 16;
   localparam int FVC_PROD_W        = 32;
   localparam int FVC_SUM_W         = 34;
   localparam int FVC_CNT_W         = 3;
   localparam int FVC_CSR_DATA_W    = 16;
   localparam int FVC_REQ_TDATA_W   = 16;
   localparam int FVC_RSP_TDATA_W   = 40;

   localparam logic [FVC_CNT_W-1:0] FVC_TAP_COUNT_RESET = 3'd7;

   typedef logic signed [FVC_SAMPLE_W-1:0] fvc_sample_type;
   typedef logic signed [FVC_SAMPLE_W-1:0] fvc_coeff_type;
   typedef logic signed [FVC_PROD_W-1:0]   fvc_prod_type;
   typedef logic signed [FVC_SUM_W-1:0]    fvc_sum_type;
   typedef logic [FVC_CNT_W-1:0]           fvc_count_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      FVC_REG_TAP_COUNT = 3'd0,
      FVC_REG_COEFF_0   = 3'd1,
      FVC_REG_COEFF_1   = 3'd2,
      FVC_REG_COEFF_2   = 3'd3,
      FVC_REG_COEFF_3   = 3'd4,
      FVC_REG_COEFF_4   = 3'd5,
      FVC_REG_COEFF_5   = 3'd6,
      FVC_REG_COEFF_6   = 3'd7
   } fvc_reg_type;

endpackage

FILE: sv/fvc_tap_cell.sv
// -----------------------------------------------------------------------------
// FIR tap cell
// One delay-line stage: holds a sample, passes it to the next cell on each
// accepted request and multiplies the sample entering it by its coefficient.
// -----------------------------------------------------------------------------
module fvc_tap_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift,
   input  fvc_pkg::fvc_sample_type sample_prev,
   input  fvc_pkg::fvc_coeff_type  coeff,
   output fvc_pkg::fvc_sample_type sample_out,
   output fvc_pkg::fvc_prod_type   product
);
   import fvc_pkg::*;

   fvc_sample_type sample_ff;
   fvc_sample_type sample_in;

   // Take the neighbour's sample on an accepted request, else hold
   assign sample_in = shift ? sample_prev : sample_ff;

   // Clear the stage on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

   assign sample_out = sample_ff;

   // Weight the sample that occupies this cell after the shift
   assign product = fvc_prod_type'(sample_prev) * fvc_prod_type'(coeff);

endmodule

FILE: sv/fvc_sum_tree.sv
// -----------------------------------------------------------------------------
// FIR registered adder tree
// Registers the tap products, then adds them pairwise one level per stage.
// Each stage has a valid bit and stalls only when its successor cannot take it.
// -----------------------------------------------------------------------------
`include "fir_valid_convolution_unit_assert.svh"

module fvc_sum_tree #(
   parameter int MAX_TAPS = fvc_pkg::FVC_MAX_TAPS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  fvc_pkg::fvc_prod_type product [MAX_TAPS],
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fvc_pkg::fvc_sum_type  sum
);
   import fvc_pkg::*;

   localparam int LEVELS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 0;
   localparam int LEAVES = 1 << LEVELS;
   localparam int NODES  = 2 * LEAVES - 1;

   // Heap order: root at index 1, leaves from LEAVES upwards
   fvc_sum_type node_ff [1:NODES];
   fvc_sum_type node_in [1:NODES];

   logic [LEVELS:0] v_ff;
   logic [LEVELS:0] v_in;
   logic [LEVELS:0] rdy;

   // Ready ripples back from the result register
   always_comb begin
      rdy[LEVELS] = !v_ff[LEVELS] || rsp_ready;
      for (int s = LEVELS - 1; s >= 0; s--) begin
         rdy[s] = !v_ff[s] || rdy[s+1];
      end
   end

   // Advance valid bits where the stage may move
   always_comb begin
      v_in    = v_ff;
      if (rdy[0]) begin
         v_in[0] = in_valid;
      end
      for (int s = 1; s <= LEVELS; s++) begin
         if (rdy[s]) begin
            v_in[s] = v_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Node next values: leaves load products, inner nodes add their children
   for (genvar i = 1; i <= NODES; i++) begin : g_node
      localparam int STAGE = LEVELS - ($clog2(i + 1) - 1);
      if (i >= LEAVES) begin : g_leaf
         if (i - LEAVES < MAX_TAPS) begin : g_used
            assign node_in[i] = (rdy[0] && in_valid) ?
                                FVC_SUM_W'(product[i-LEAVES]) : node_ff[i];
         end else begin : g_pad
            assign node_in[i] = '0;
         end
      end else begin : g_add
         assign node_in[i] = (rdy[STAGE] && v_ff[STAGE-1]) ?
                             node_ff[2*i] + node_ff[2*i+1] : node_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 1; i <= NODES; i++) begin
         node_ff[i] <= node_in[i];
      end
   end

   assign in_ready  = rdy[0];
   assign rsp_valid = v_ff[LEVELS];
   assign sum       = node_ff[1];

   // A stall at the input means every stage holds a request
   `FVC_ASSERT_IMPLY(stall_only_when_full, clock, reset, !rdy[0], &v_ff)
   // A waiting result stays put until taken
   `FVC_ASSERT_NEXT(result_held, clock, reset, v_ff[LEVELS] && !rsp_ready,
                    v_ff[LEVELS] && $stable(node_ff[1]))
   // A taken request occupies the first stage
   `FVC_ASSERT_NEXT(input_taken, clock, reset, in_valid && rdy[0], v_ff[0])

endmodule

FILE: sv/fir_valid_convolution_unit.sv
// Pipeline: an accepted request is registered in one product stage, then in
// one adder level each before its result appears.
// Throughput: one request per cycle; every stage stalls only when the next is full.
// Reset (synchronous, active high) empties the pipeline, clears the delay line,
// the fill count and coefficients and sets the tap count to seven.
// -----------------------------------------------------------------------------
// FIR valid-convolution unit
// Direct-form FIR over a chain of tap cells that emits only full windows
// of the current frame, at full Q4.30 precision.
// -----------------------------------------------------------------------------
`include "fir_valid_convolution_unit_assert.svh"

module fir_valid_convolution_unit #(
   parameter int MAX_TAPS = fvc_pkg::FVC_MAX_TAPS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [fvc_pkg::FVC_REQ_TDATA_W-1:0]  req_tdata,   // [15:0] sample
   input  logic                                 req_tuser,   // [0] frame_start
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fvc_pkg::FVC_RSP_TDATA_W-1:0]  rsp_tdata,   // [33:0] filtered
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  fvc_pkg::fvc_reg_type                 csr_index,
   input  logic [fvc_pkg::FVC_CSR_DATA_W-1:0]   csr_data
);
   import fvc_pkg::*;

   fvc_count_type  tap_count_ff;
   fvc_count_type  tap_count_in;
   fvc_coeff_type  coeff_ff [MAX_TAPS];
   fvc_coeff_type  coeff_in [MAX_TAPS];
   fvc_count_type  fill_ff;
   fvc_count_type  fill_in;
   fvc_count_type  fill_step;
   fvc_count_type  window_len;
   logic           accept;
   logic           emit;
   logic           tree_ready;
   fvc_sum_type    tree_sum;
   fvc_coeff_type  coeff_sel [MAX_TAPS];
   fvc_sample_type chain [MAX_TAPS];
   fvc_prod_type   product [MAX_TAPS];

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   // Decode register writes
   always_comb begin
      tap_count_in = tap_count_ff;
      coeff_in     = coeff_ff;
      if (csr_valid) begin
         unique case (csr_index)
            FVC_REG_TAP_COUNT: begin
               tap_count_in = csr_data[FVC_CNT_W-1:0];
            end
            default: begin
               for (int k = 0; k < MAX_TAPS; k++) begin
                  if (int'(csr_index) == int'(FVC_REG_COEFF_0) + k) begin
                     coeff_in[k] = csr_data;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= FVC_TAP_COUNT_RESET;
         for (int k = 0; k < MAX_TAPS; k++) begin
            coeff_ff[k] <= '0;
         end
      end else begin
         tap_count_ff <= tap_count_in;
         coeff_ff     <= coeff_in;
      end
   end

   // Clamp the tap count to the range the chain supports
   always_comb begin
      if (tap_count_ff == '0) begin
         window_len = FVC_CNT_W'(1);
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         window_len = FVC_CNT_W'(MAX_TAPS);
      end else begin
         window_len = tap_count_ff;
      end
   end

   // Route coefficients: the newest sample takes the last tap in use
   always_comb begin
      for (int j = 0; j < MAX_TAPS; j++) begin
         coeff_sel[j] = '0;
         for (int k = 0; k < MAX_TAPS; k++) begin
            if (k + j + 1 == int'(window_len)) begin
               coeff_sel[j] = coeff_ff[k];
            end
         end
      end
   end

   assign accept = req_tvalid && req_tready;

   // Count samples of the current frame, saturating at the chain length
   always_comb begin
      if (req_tuser) begin
         fill_step = FVC_CNT_W'(1);
      end else if (int'(fill_ff) < MAX_TAPS) begin
         fill_step = fill_ff + FVC_CNT_W'(1);
      end else begin
         fill_step = fill_ff;
      end
      fill_in = accept ? fill_step : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Emit only when the whole window lies in the current frame
   assign emit = fill_step >= window_len;

   // Chain of tap cells
   assign chain[0] = fvc_sample_type'(req_tdata[FVC_SAMPLE_W-1:0]);

   for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
      if (j < MAX_TAPS - 1) begin : g_link
         fvc_tap_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (accept),
            .sample_prev (chain[j]),
            .coeff       (coeff_sel[j]),
            .sample_out  (chain[j+1]),
            .product     (product[j])
         );
      end else begin : g_end
         fvc_tap_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .shift       (accept),
            .sample_prev (chain[j]),
            .coeff       (coeff_sel[j]),
            .sample_out  (),
            .product     (product[j])
         );
      end
   end

   // Sum the products in a registered tree
   fvc_sum_tree #(
      .MAX_TAPS (MAX_TAPS)
   ) u_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid && emit),
      .in_ready  (tree_ready),
      .product   (product),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .sum       (tree_sum)
   );

   assign req_tready = tree_ready;
   assign rsp_tdata  = {{(FVC_RSP_TDATA_W - FVC_SUM_W){1'b0}}, tree_sum};

   // A frame mark restarts the fill count at one
   `FVC_ASSERT_NEXT(frame_restart, clock, reset, accept && req_tuser,
                    fill_ff == FVC_CNT_W'(1))
   // The fill count never passes the chain length
   `FVC_ASSERT_IMPLY(fill_bounded, clock, reset, 1'b1, int'(fill_ff) <= MAX_TAPS)
   // Without an accepted request the fill count holds
   `FVC_ASSERT_NEXT(fill_hold, clock, reset, !accept, $stable(fill_ff))

endmodule
